@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the polyline offset RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PMO_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("pmo assertion failed");

// Next-cycle implication, checked out of reset.
`define PMO_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("pmo assertion failed");

`endif

@@ rtl/core/pmo_pkg.sv @@
// Package for the polyline offset block: widths, constants, sequencer codes.
// No dependencies.
package pmo_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int OFF_W           = 16;
	localparam int UNIT_W          = 32;
	localparam int PROD_W          = 64;
	localparam int DIV_NUM_W       = 64;
	localparam int DIV_DEN_W       = 32;
	localparam int SH_W            = 32;

	localparam logic [DIV_DEN_W-1:0] UNIT_ONE = 32'h4000_0000;
	localparam logic [DIV_DEN_W-1:0] COS_MIN  = 32'd10737418;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_BEGIN,
		ST_MAG,
		ST_NORM,
		ST_SQ,
		ST_SQRT,
		ST_SQRT_W,
		ST_UDIV,
		ST_UDIV_W,
		ST_RET,
		ST_DOT,
		ST_COS,
		ST_SMUL,
		ST_SDIV,
		ST_SDIV_W,
		ST_OUT,
		ST_NEXT,
		ST_UPDATE
	} state_t;

	typedef enum logic [2:0] {
		PH_END0,
		PH_C2L,
		PH_C2N,
		PH_BIS,
		PH_FIN
	} phase_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

@@ rtl/core/polyline_miter_offset_top.sv @@
// Top level of the polyline miter offset block: sequencer and datapath.
// Depends on pmo_pkg, pmo_mul, pmo_div, pmo_isqrt and assert_macros.svh.
//
//  channel | dir | fields                                   | handshake
//  s_      | in  | tdata: pos_x, pos_y, pos_z; tlast: final | s_tvalid/s_tready
//  m_      | out | tdata: out_x, out_y, out_z; tlast: eol   | m_tvalid/m_tready
//  cfg_    | in  | cfg_data: offset_distance (Q8.8)         | cfg_valid/cfg_ready
//
// Shared multiplier, 1 bit/cycle divider and 1 bit/cycle root under one sequencer.
// A unit vector: normalize shifts, sum of squares, square root, then one divide per axis.
// End point: one unit vector; inner point: three unit vectors and a dot product; both then
// run two shift divides. A final point adds one more end-point pass.
// s_tready is high only in idle; a full output word stalls the sequencer.
// Reset clears the held points, the point count, the offset and m_tvalid.
`include "assert_macros.svh"

module polyline_miter_offset_top #(
	parameter int COORD_WIDTH = pmo_pkg::COORD_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// pos_x, pos_y, pos_z from bit 0 up, zero pad to bytes
	input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// out_x, out_y, out_z from bit 0 up, zero pad to bytes
	output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic m_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [pmo_pkg::OFF_W-1:0] cfg_data
);

	localparam int CW     = COORD_WIDTH;
	localparam int DATA_W = ((3*CW+7)/8)*8;
	localparam int VW     = (CW + 1 > 33) ? CW + 1 : 33;
	localparam int UW     = pmo_pkg::UNIT_W;
	localparam int PW     = pmo_pkg::PROD_W;
	localparam int SW     = pmo_pkg::SH_W;
	localparam int SUM_W  = ((CW > SW) ? CW : SW) + 1;
	localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	pmo_pkg::state_t state_q, state_d;
	pmo_pkg::phase_t phase_q;

	// held points: index 0 newest
	logic signed [CW-1:0] h0x_q, h0y_q, h0z_q, h1x_q, h1y_q, h1z_q;
	logic [1:0]           cnt_q;
	logic signed [pmo_pkg::OFF_W-1:0] off_q;

	logic signed [CW-1:0] px_q, py_q, pz_q;
	logic                 fin_q;

	logic signed [VW-1:0] vin_q [3];
	logic [VW-1:0]        mag_q [3];
	logic signed [UW-1:0] u_q [3];
	logic signed [UW-1:0] ua_q [3];
	logic [PW-1:0]        sum_q;
	logic [UW-1:0]        len_q;
	logic [pmo_pkg::DIV_DEN_W-1:0] den_q;
	logic signed [SW-1:0] sx_q, sz_q;
	logic                 sneg_q;
	logic [1:0]           idx_q;

	logic                 out_valid_q;
	logic signed [CW-1:0] ox_q, oy_q, oz_q;
	logic                 olast_q;

	logic signed [UW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] mul_p;
	pmo_pkg::div_req_t    div_req;
	pmo_pkg::unit_stat_t  div_stat, sqrt_stat;
	logic [pmo_pkg::DIV_NUM_W-1:0] div_quo;
	logic                 sqrt_start;
	logic [UW-1:0]        sqrt_root;

	logic [VW-1:0]        or_mag;
	logic                 out_free;
	logic [PW-1:0]        pmag;
	logic [PW-1:0]        dmag;
	logic [PW-1:0]        cosq;
	logic signed [SW-1:0] qs;
	logic signed [CW-1:0] ptx, pty, ptz;
	logic signed [SUM_W-1:0] sumx, sumz;

	assign or_mag   = mag_q[0] | mag_q[1] | mag_q[2];
	assign out_free = !out_valid_q || m_tready;
	assign pmag     = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);
	assign dmag     = sum_q[PW-1] ? (~sum_q + 1'b1) : sum_q;
	assign cosq     = dmag >> 30;
	assign qs       = SW'(div_quo);

	// offset copy of the held point, or of the final point
	assign ptx  = (phase_q == pmo_pkg::PH_FIN) ? px_q : h0x_q;
	assign pty  = (phase_q == pmo_pkg::PH_FIN) ? py_q : h0y_q;
	assign ptz  = (phase_q == pmo_pkg::PH_FIN) ? pz_q : h0z_q;
	assign sumx = SUM_W'(ptx) + SUM_W'(sx_q);
	assign sumz = SUM_W'(ptz) + SUM_W'(sz_q);

	pmo_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	pmo_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .stat(div_stat), .quo(div_quo)
	);

	pmo_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .v(sum_q),
		.stat(sqrt_stat), .root(sqrt_root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pmo_pkg::ST_IDLE:   if (s_tvalid) state_d = pmo_pkg::ST_BEGIN;
			pmo_pkg::ST_BEGIN:  state_d = (cnt_q == 2'd0) ? pmo_pkg::ST_UPDATE : pmo_pkg::ST_MAG;
			pmo_pkg::ST_MAG:    state_d = pmo_pkg::ST_NORM;
			pmo_pkg::ST_NORM: begin
				if (or_mag == '0) state_d = pmo_pkg::ST_RET;
				else if (!(|or_mag[VW-1:30]) && or_mag[29]) state_d = pmo_pkg::ST_SQ;
			end
			pmo_pkg::ST_SQ:     if (idx_q == 2'd3) state_d = pmo_pkg::ST_SQRT;
			pmo_pkg::ST_SQRT:   state_d = pmo_pkg::ST_SQRT_W;
			pmo_pkg::ST_SQRT_W: if (sqrt_stat.done) state_d = pmo_pkg::ST_UDIV;
			pmo_pkg::ST_UDIV:   state_d = pmo_pkg::ST_UDIV_W;
			pmo_pkg::ST_UDIV_W: begin
				if (div_stat.done) begin
					state_d = (idx_q == 2'd2) ? pmo_pkg::ST_RET : pmo_pkg::ST_UDIV;
				end
			end
			pmo_pkg::ST_RET: begin
				unique case (phase_q)
					pmo_pkg::PH_C2L, pmo_pkg::PH_C2N: state_d = pmo_pkg::ST_MAG;
					pmo_pkg::PH_BIS:                 state_d = pmo_pkg::ST_DOT;
					default:                         state_d = pmo_pkg::ST_SMUL;
				endcase
			end
			pmo_pkg::ST_DOT:    if (idx_q == 2'd3) state_d = pmo_pkg::ST_COS;
			pmo_pkg::ST_COS:    state_d = pmo_pkg::ST_SMUL;
			pmo_pkg::ST_SMUL:   state_d = pmo_pkg::ST_SDIV;
			pmo_pkg::ST_SDIV:   state_d = pmo_pkg::ST_SDIV_W;
			pmo_pkg::ST_SDIV_W: begin
				if (div_stat.done) begin
					state_d = idx_q[0] ? pmo_pkg::ST_OUT : pmo_pkg::ST_SMUL;
				end
			end
			pmo_pkg::ST_OUT:    if (out_free) state_d = pmo_pkg::ST_NEXT;
			pmo_pkg::ST_NEXT: begin
				if (phase_q != pmo_pkg::PH_FIN && fin_q) state_d = pmo_pkg::ST_MAG;
				else state_d = pmo_pkg::ST_UPDATE;
			end
			pmo_pkg::ST_UPDATE: state_d = pmo_pkg::ST_IDLE;
			default:            state_d = pmo_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and shared unit operands
	always_comb begin
		s_tready    = 1'b0;
		sqrt_start  = 1'b0;
		div_req     = '0;
		mul_a       = '0;
		mul_b       = '0;
		unique case (state_q)
			pmo_pkg::ST_IDLE: s_tready = 1'b1;
			pmo_pkg::ST_SQ: begin
				if (idx_q != 2'd3) begin
					mul_a = UW'(mag_q[idx_q][29:0]);
					mul_b = UW'(mag_q[idx_q][29:0]);
				end
			end
			pmo_pkg::ST_DOT: begin
				if (idx_q != 2'd3) begin
					mul_a = -ua_q[idx_q];
					mul_b = u_q[idx_q];
				end
			end
			pmo_pkg::ST_SMUL: begin
				mul_a = idx_q[0] ? u_q[0] : -u_q[2];
				mul_b = UW'(off_q);
			end
			pmo_pkg::ST_SQRT: sqrt_start = 1'b1;
			pmo_pkg::ST_UDIV: begin
				if (idx_q != 2'd3) begin
					div_req.start = 1'b1;
					div_req.num   = {4'b0, mag_q[idx_q][29:0], 30'b0};
					div_req.den   = len_q;
				end
			end
			pmo_pkg::ST_SDIV: begin
				div_req.start = 1'b1;
				div_req.num   = pmag << 8;
				div_req.den   = den_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pmo_pkg::ST_IDLE;
			phase_q     <= pmo_pkg::PH_END0;
			cnt_q       <= 2'd0;
			off_q       <= '0;
			h0x_q       <= '0;
			h0y_q       <= '0;
			h0z_q       <= '0;
			h1x_q       <= '0;
			h1y_q       <= '0;
			h1z_q       <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) off_q <= cfg_data;
			// load a new word when free, else drop valid once the word is taken
			if (state_q == pmo_pkg::ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			unique case (state_q)
				pmo_pkg::ST_BEGIN: begin
					phase_q <= (cnt_q == 2'd1) ? pmo_pkg::PH_END0 : pmo_pkg::PH_C2L;
				end
				pmo_pkg::ST_NORM:   idx_q <= 2'd0;
				pmo_pkg::ST_SQ:     if (idx_q == 2'd3) idx_q <= 2'd0; else idx_q <= idx_q + 1'b1;
				pmo_pkg::ST_DOT:    if (idx_q == 2'd3) idx_q <= 2'd0; else idx_q <= idx_q + 1'b1;
				pmo_pkg::ST_SQRT_W: idx_q <= 2'd0;
				pmo_pkg::ST_UDIV_W: if (div_stat.done) idx_q <= idx_q + 1'b1;
				pmo_pkg::ST_RET: begin
					idx_q <= 2'd0;
					if (phase_q == pmo_pkg::PH_C2L) phase_q <= pmo_pkg::PH_C2N;
					if (phase_q == pmo_pkg::PH_C2N) phase_q <= pmo_pkg::PH_BIS;
				end
				pmo_pkg::ST_COS:    idx_q <= 2'd0;
				pmo_pkg::ST_SDIV_W: if (div_stat.done) idx_q <= idx_q + 1'b1;
				pmo_pkg::ST_NEXT: begin
					if (phase_q != pmo_pkg::PH_FIN && fin_q) phase_q <= pmo_pkg::PH_FIN;
				end
				pmo_pkg::ST_UPDATE: begin
					if (fin_q) begin
						cnt_q <= 2'd0;
					end else begin
						h1x_q <= h0x_q;
						h1y_q <= h0y_q;
						h1z_q <= h0z_q;
						h0x_q <= px_q;
						h0y_q <= py_q;
						h0z_q <= pz_q;
						if (cnt_q != 2'd2) cnt_q <= cnt_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			pmo_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					px_q  <= s_tdata[CW-1:0];
					py_q  <= s_tdata[2*CW-1:CW];
					pz_q  <= s_tdata[3*CW-1:2*CW];
					fin_q <= s_tlast;
				end
			end
			pmo_pkg::ST_BEGIN: begin
				// end point: segment toward the new point; inner: leg back
				if (cnt_q == 2'd1) begin
					vin_q[0] <= VW'(px_q) - VW'(h0x_q);
					vin_q[1] <= VW'(py_q) - VW'(h0y_q);
					vin_q[2] <= VW'(pz_q) - VW'(h0z_q);
				end else begin
					vin_q[0] <= VW'(h1x_q) - VW'(h0x_q);
					vin_q[1] <= VW'(h1y_q) - VW'(h0y_q);
					vin_q[2] <= VW'(h1z_q) - VW'(h0z_q);
				end
			end
			pmo_pkg::ST_MAG: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i] <= vin_q[i][VW-1] ? VW'(-vin_q[i]) : VW'(vin_q[i]);
				end
			end
			pmo_pkg::ST_NORM: begin
				// scale so the largest magnitude lands in [2^29, 2^30)
				if (or_mag == '0) begin
					for (int i = 0; i < 3; i++) u_q[i] <= '0;
				end else if (|or_mag[VW-1:30]) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (!or_mag[29]) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end
				sum_q <= '0;
			end
			pmo_pkg::ST_SQ, pmo_pkg::ST_DOT: begin
				if (idx_q != 2'd0) sum_q <= sum_q + PW'(mul_p);
			end
			pmo_pkg::ST_SQRT_W: if (sqrt_stat.done) len_q <= sqrt_root;
			pmo_pkg::ST_UDIV_W: begin
				if (div_stat.done && idx_q != 2'd3) begin
					u_q[idx_q] <= vin_q[idx_q][VW-1] ? -UW'(div_quo) : UW'(div_quo);
				end
			end
			pmo_pkg::ST_RET: begin
				unique case (phase_q)
					pmo_pkg::PH_C2L: begin
						for (int i = 0; i < 3; i++) ua_q[i] <= u_q[i];
						vin_q[0] <= VW'(px_q) - VW'(h0x_q);
						vin_q[1] <= VW'(py_q) - VW'(h0y_q);
						vin_q[2] <= VW'(pz_q) - VW'(h0z_q);
					end
					pmo_pkg::PH_C2N: begin
						for (int i = 0; i < 3; i++) vin_q[i] <= VW'(u_q[i]) - VW'(ua_q[i]);
					end
					pmo_pkg::PH_BIS: sum_q <= '0;
					default: den_q <= pmo_pkg::UNIT_ONE;
				endcase
			end
			pmo_pkg::ST_COS: begin
				// miter: divide by the cosine only above the threshold
				if (!sum_q[PW-1] && cosq > PW'(pmo_pkg::COS_MIN)) begin
					den_q <= cosq[pmo_pkg::DIV_DEN_W-1:0];
				end else begin
					den_q <= pmo_pkg::UNIT_ONE;
				end
			end
			pmo_pkg::ST_SDIV: sneg_q <= mul_p[PW-1];
			pmo_pkg::ST_SDIV_W: begin
				if (div_stat.done) begin
					if (idx_q[0]) sz_q <= sneg_q ? -qs : qs;
					else          sx_q <= sneg_q ? -qs : qs;
				end
			end
			pmo_pkg::ST_OUT: begin
				if (out_free) begin
					ox_q    <= (sumx > SAT_HI) ? SAT_HI[CW-1:0] :
					           (sumx < SAT_LO) ? SAT_LO[CW-1:0] : sumx[CW-1:0];
					oz_q    <= (sumz > SAT_HI) ? SAT_HI[CW-1:0] :
					           (sumz < SAT_LO) ? SAT_LO[CW-1:0] : sumz[CW-1:0];
					oy_q    <= pty;
					olast_q <= (phase_q == pmo_pkg::PH_FIN);
				end
			end
			pmo_pkg::ST_NEXT: begin
				// final point: segment from the newest held point to the new one
				vin_q[0] <= VW'(px_q) - VW'(h0x_q);
				vin_q[1] <= VW'(py_q) - VW'(h0y_q);
				vin_q[2] <= VW'(pz_q) - VW'(h0z_q);
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = DATA_W'({oz_q, oy_q, ox_q});
	assign m_tlast   = olast_q;

	`PMO_ASSERT_NXT(a_accept_leaves_idle, s_tvalid && s_tready, state_q != pmo_pkg::ST_IDLE)
	`PMO_ASSERT_IMP(a_div_free, div_req.start, !div_stat.busy && div_req.den != '0)
	`PMO_ASSERT_IMP(a_norm_range, state_q == pmo_pkg::ST_SQ && idx_q == 2'd0,
		!(|or_mag[VW-1:30]) && or_mag[29])
	`PMO_ASSERT_IMP(a_out_no_clobber, state_q == pmo_pkg::ST_OUT && out_valid_q && !m_tready,
		state_d == pmo_pkg::ST_OUT)

endmodule

@@ rtl/core/pmo_mul.sv @@
// Shared signed 32x32 multiplier with a registered product.
// Depends on pmo_pkg.
module pmo_mul (
	input  logic                              clk,
	input  logic signed [pmo_pkg::UNIT_W-1:0] a,
	input  logic signed [pmo_pkg::UNIT_W-1:0] b,
	output logic signed [pmo_pkg::PROD_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

@@ rtl/core/pmo_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pmo_pkg.
module pmo_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pmo_pkg::div_req_t                    req,
	output pmo_pkg::unit_stat_t                  stat,
	output logic [pmo_pkg::DIV_NUM_W-1:0]        quo
);

	localparam int NW = pmo_pkg::DIV_NUM_W;
	localparam int DW = pmo_pkg::DIV_DEN_W;

	logic [NW-1:0]        quo_q;
	logic [DW-1:0]        rem_q;
	logic [DW-1:0]        den_q;
	logic [$clog2(NW)-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DW:0]          trial;
	logic [DW:0]          diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ($clog2(NW))'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

@@ rtl/core/pmo_isqrt.sv @@
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on pmo_pkg.
module pmo_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pmo_pkg::PROD_W-1:0]    v,
	output pmo_pkg::unit_stat_t           stat,
	output logic [pmo_pkg::UNIT_W-1:0]    root
);

	localparam int PW = pmo_pkg::PROD_W;

	logic [PW-1:0] rem_q;
	logic [PW-1:0] res_q;
	logic [PW-1:0] bit_q;
	logic          busy_q;
	logic          done_q;
	logic [PW-1:0] t;

	assign t = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= v;
			res_q <= '0;
			bit_q <= {2'b01, {(PW-2){1'b0}}};
		end else if (busy_q) begin
			if (rem_q >= t) begin
				rem_q <= rem_q - t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = res_q[pmo_pkg::UNIT_W-1:0];

endmodule
